>>> sv/ldc_pkg.sv
package ldc_pkg;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_NAME  = 2'd2;
    localparam logic [1:0] ACT_NUM   = 2'd3;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_RANGE     = 3'd1;
    localparam logic [2:0] STS_SMALL     = 3'd2;
    localparam logic [2:0] STS_DIMS      = 3'd3;
    localparam logic [2:0] STS_FULL      = 3'd4;
    localparam logic [2:0] STS_NOT_FOUND = 3'd5;
    localparam logic [2:0] STS_BAD_NUM   = 3'd6;

    localparam int NameBytes = 16;
    localparam logic signed [31:0] DimLimit = 32'sd4096;
    localparam logic signed [31:0] PicHeaderBytes = 32'sd8;
    localparam logic [7:0] CaseShift = 8'd32;

    // Token that walks along the directory cells.
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] name_lo;
        logic [63:0] name_hi;
        logic [30:0] pos;
        logic [15:0] target;
        logic [16:0] count;
        logic        hit;
        logic [15:0] hit_idx;
        logic [30:0] hit_pos;
    } t_token;

    // Lowercase A..Z and zero every byte from the first NUL onwards.
    function automatic logic [127:0] tidy_name(input logic [127:0] raw);
        logic [127:0] res;
        logic         ended;
        logic [7:0]   c;
        res   = '0;
        ended = 1'b0;
        for (int i = 0; i < NameBytes; i++) begin
            c = raw[i*8 +: 8];
            if (c == 8'd0) ended = 1'b1;
            if (!ended) begin
                if (c >= 8'd65 && c <= 8'd90) c = c + CaseShift;
                res[i*8 +: 8] = c;
            end
        end
        return res;
    endfunction

endpackage

>>> sv/ldc_cell.sv
module ldc_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  ldc_pkg::t_token i_tok,
    output logic            o_tok_valid,
    output ldc_pkg::t_token o_tok
);
    import ldc_pkg::*;

    localparam logic [15:0] MyIdx = 16'(IDX);

    logic [63:0] r_name_lo;
    logic [63:0] r_name_hi;
    logic [30:0] r_pos;
    logic        r_tok_valid;
    t_token      r_tok;
    t_token      n_tok;
    logic        w_write;
    logic        w_match;

    always_comb begin
        w_write = i_tok_valid && !i_tok.hit && i_tok.op == ACT_LOAD && i_tok.target == MyIdx;
        w_match = i_tok_valid && !i_tok.hit &&
                  ((i_tok.op == ACT_NAME && {1'b0, MyIdx} < i_tok.count &&
                    r_name_lo == i_tok.name_lo && r_name_hi == i_tok.name_hi) ||
                   (i_tok.op == ACT_NUM && i_tok.target == MyIdx));
        n_tok = i_tok;
        if (w_write) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = MyIdx;
            n_tok.hit_pos = i_tok.pos;
        end else if (w_match) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = MyIdx;
            n_tok.hit_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_name_lo <= i_tok.name_lo;
            r_name_hi <= i_tok.name_hi;
            r_pos     <= i_tok.pos;
        end
        if (i_tok_valid) r_tok <= n_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

>>> sv/lump_directory_checker_lookup_core.sv
// Directory of named archive entries with entry checking and lookup.
//
// The input channel (i_valid, o_stall) carries one action per transfer:
// clear, load entry, lookup by name or lookup by number. The output channel
// (o_valid, i_stall) carries exactly one result per action. The block works
// on one action at a time and holds o_stall high until it is ready again.
// The entries live in a row of MAX_ENTRIES cells; a request token moves one
// cell per cycle, so the length of the cell chain sets the time of every
// action that walks it. A lookup by name or by a valid number walks the
// chain directly; a load first passes the check states S_CHK and S_DEC and
// walks the chain only if it is stored. A clear, an out-of-range number or
// a rejected load gives its result without walking the chain.
// The result sits in an output register; the next transfer can be taken
// while it waits, and a finished result waits for the register while the
// receiver stalls, which lengthens the item by the cycles of that stall.
// Reset empties the directory, sets file_size to 0 and the picture type to
// 66. Configuration is written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce.
module lump_directory_checker_lookup_core #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_name_low,
    input  logic [63:0] i_name_high,
    input  logic signed [31:0] i_file_position,
    input  logic signed [31:0] i_disk_size,
    input  logic [7:0]  i_entry_type,
    input  logic signed [31:0] i_pic_width,
    input  logic signed [31:0] i_pic_height,
    input  logic [15:0] i_entry_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_found_index,
    output logic [30:0] o_found_position
);
    import ldc_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]    r_state;
    logic [30:0]   r_file_size;
    logic [7:0]    r_pic_code;
    logic [CW-1:0] r_count;
    logic [1:0]    r_op;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_size;
    logic [7:0]    r_type;
    logic signed [31:0] r_w;
    logic signed [31:0] r_h;
    logic          r_range_bad;
    logic          r_is_pic;
    logic          r_small;
    logic          r_dim_bad;
    logic [25:0]   r_prod;
    logic [2:0]    r_res_status;
    logic [7:0]    r_res_idx;
    logic [30:0]   r_res_pos;
    logic          r_l_valid;
    t_token        r_l_tok;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [7:0]    r_out_idx;
    logic [30:0]   r_out_pos;

    logic          w_accept;
    logic [127:0]  w_tidy;
    logic          w_tv  [0:MAX_ENTRIES];
    t_token        w_tok [0:MAX_ENTRIES];
    logic          w_fin_go;
    logic signed [31:0] w_room;
    logic          w_num_bad;
    logic          w_load_ok;
    logic          w_launch;

    assign w_accept  = i_valid && !o_stall;
    assign w_tidy    = tidy_name({i_name_high, i_name_low});
    assign w_fin_go  = (r_state == S_FIN) && (!r_out_valid || !i_stall);
    assign w_room    = r_size - PicHeaderBytes;
    assign w_num_bad = 17'(i_entry_number) >= 17'(r_count);

    // A load that passed every check and finds room is sent down the chain.
    assign w_load_ok = !r_range_bad && !(r_is_pic && r_small) &&
                       !(r_is_pic && (r_dim_bad || {6'd0, r_prod} > w_room)) &&
                       r_count != MaxCount;
    assign w_launch  = (r_state == S_IDLE && w_accept &&
                        (i_action == ACT_NAME || (i_action == ACT_NUM && !w_num_bad))) ||
                       (r_state == S_DEC && w_load_ok);

    // The cell chain: cell k holds directory entry k.
    assign w_tv[0]  = r_l_valid;
    assign w_tok[0] = r_l_tok;
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        ldc_cell #(.IDX(k)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok_valid (w_tv[k]),
            .i_tok       (w_tok[k]),
            .o_tok_valid (w_tv[k+1]),
            .o_tok       (w_tok[k+1])
        );
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_action;
            r_pos  <= i_file_position;
            r_size <= i_disk_size;
            r_type <= i_entry_type;
            r_w    <= i_pic_width;
            r_h    <= i_pic_height;
        end
        if (r_state == S_CHK) begin
            r_range_bad <= r_pos[31] || r_size[31] ||
                           ({1'b0, r_pos} + {1'b0, r_size} > {2'b00, r_file_size});
            r_is_pic    <= r_type == r_pic_code;
            r_small     <= r_size < PicHeaderBytes;
            r_dim_bad   <= r_w <= 32'sd0 || r_h <= 32'sd0 ||
                           r_w > DimLimit || r_h > DimLimit;
            r_prod      <= r_w[12:0] * r_h[12:0];
        end
        if (w_fin_go) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_pos    <= r_res_pos;
        end
    end

    // Control: sequencer, directory count, configuration and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_file_size  <= '0;
            r_pic_code   <= 8'd66;
            r_count      <= '0;
            r_l_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_res_status <= STS_OK;
            r_res_idx    <= '0;
            r_res_pos    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'b0) r_file_size <= i_cfg_data;
                else r_pic_code <= i_cfg_data[7:0];
            end
            r_l_valid <= w_launch;
            if (w_fin_go) r_out_valid <= 1'b1;
            else if (o_valid && !i_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_status <= (i_action == ACT_NUM && w_num_bad) ?
                                        STS_BAD_NUM : STS_OK;
                        r_res_idx    <= '0;
                        r_res_pos    <= '0;
                        r_l_tok.op      <= i_action;
                        r_l_tok.name_lo <= w_tidy[63:0];
                        r_l_tok.name_hi <= w_tidy[127:64];
                        r_l_tok.pos     <= i_file_position[30:0];
                        r_l_tok.target  <= i_entry_number;
                        r_l_tok.count   <= 17'(r_count);
                        r_l_tok.hit     <= 1'b0;
                        r_l_tok.hit_idx <= '0;
                        r_l_tok.hit_pos <= '0;
                        case (i_action)
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_FIN;
                            end
                            ACT_LOAD: r_state <= S_CHK;
                            ACT_NAME: r_state <= S_RUN;
                            default: begin
                                if (w_num_bad) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_RUN;
                                end
                            end
                        endcase
                    end
                end
                S_CHK: r_state <= S_DEC;
                S_DEC: begin
                    r_state <= S_FIN;
                    if (r_range_bad) begin
                        r_res_status <= STS_RANGE;
                    end else if (r_is_pic && r_small) begin
                        r_res_status <= STS_SMALL;
                    end else if (r_is_pic && (r_dim_bad || {6'd0, r_prod} > w_room)) begin
                        r_res_status <= STS_DIMS;
                    end else if (r_count == MaxCount) begin
                        r_res_status <= STS_FULL;
                    end else begin
                        r_l_tok.target <= 16'(r_count);
                        r_state        <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_tv[MAX_ENTRIES]) begin
                        r_state <= S_FIN;
                        if (w_tok[MAX_ENTRIES].hit) begin
                            r_res_status <= STS_OK;
                            r_res_idx    <= w_tok[MAX_ENTRIES].hit_idx[7:0];
                            r_res_pos    <= w_tok[MAX_ENTRIES].hit_pos;
                            if (r_op == ACT_LOAD) r_count <= r_count + 1'b1;
                        end else begin
                            r_res_status <= STS_NOT_FOUND;
                        end
                    end
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = r_state != S_IDLE;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_index    = r_out_idx;
    assign o_found_position = r_out_pos;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxCount)
        else $error("directory count beyond capacity");

    a_chain_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tv[MAX_ENTRIES] |-> r_state == S_RUN)
        else $error("token left the cell chain outside a search");

    a_load_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && w_tv[MAX_ENTRIES] && r_op == ACT_LOAD)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("stored entry not counted");

endmodule
